>>> design/cpub_pkg.sv
package cpub_pkg;

  localparam int unsigned CpW   = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned SelW  = 3;
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned IdxW  = 2;

  localparam logic [SelW-1:0] CODEC_UTF8    = 3'd0;
  localparam logic [SelW-1:0] CODEC_UTF16LE = 3'd1;
  localparam logic [SelW-1:0] CODEC_UTF16BE = 3'd2;
  localparam logic [SelW-1:0] CODEC_UTF32LE = 3'd3;
  localparam logic [SelW-1:0] CODEC_UTF32BE = 3'd4;

  localparam logic [SelW-1:0] CODEC_RESET = CODEC_UTF8;

  // One encoded code point: bytes in stream order, index of the final byte.
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [IdxW-1:0]                last_idx;
    logic                           bad;
  } enc_word_t;

endpackage

>>> design/cpub_enc.sv
module cpub_enc import cpub_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [CpW-1:0]       in_code_point,
  output logic                 in_stall,
  input  logic [SelW-1:0]      codec,
  input  logic                 word_take,
  output logic                 word_valid,
  output enc_word_t            word
);

  logic      a_valid_r, a_valid_nxt;
  enc_word_t a_word_r, a_word_nxt;
  logic      in_fire;
  logic      codec_ok;
  logic      reject;
  logic [CpW-1:0] cp;
  logic [19:0] v;
  logic [15:0] u0, u1;

  assign cp       = in_code_point;
  assign in_stall = a_valid_r && !word_take;
  assign in_fire  = in_valid && !in_stall;

  // surrogates and values above the last plane cannot be encoded in UTF-8/16
  assign reject = (cp > 32'h0010_FFFF) || (cp >= 32'h0000_D800 && cp <= 32'h0000_DFFF);
  assign v      = 20'(cp[20:0] - 21'h01_0000);
  assign u0     = {6'b110110, v[19:10]};
  assign u1     = {6'b110111, v[9:0]};

  always_comb begin
    a_word_nxt = '0;
    codec_ok   = 1'b1;
    unique case (codec)
      CODEC_UTF8: begin
        if (reject) begin
          a_word_nxt.bad = 1'b1;
        end else if (cp < 32'h80) begin
          a_word_nxt.bytes[0] = cp[7:0];
          a_word_nxt.last_idx = 2'd0;
        end else if (cp < 32'h800) begin
          a_word_nxt.bytes[0] = {3'b110, cp[10:6]};
          a_word_nxt.bytes[1] = {2'b10, cp[5:0]};
          a_word_nxt.last_idx = 2'd1;
        end else if (cp < 32'h1_0000) begin
          a_word_nxt.bytes[0] = {4'b1110, cp[15:12]};
          a_word_nxt.bytes[1] = {2'b10, cp[11:6]};
          a_word_nxt.bytes[2] = {2'b10, cp[5:0]};
          a_word_nxt.last_idx = 2'd2;
        end else begin
          a_word_nxt.bytes[0] = {5'b11110, cp[20:18]};
          a_word_nxt.bytes[1] = {2'b10, cp[17:12]};
          a_word_nxt.bytes[2] = {2'b10, cp[11:6]};
          a_word_nxt.bytes[3] = {2'b10, cp[5:0]};
          a_word_nxt.last_idx = 2'd3;
        end
      end
      CODEC_UTF16LE: begin
        if (reject) begin
          a_word_nxt.bad = 1'b1;
        end else if (cp < 32'h1_0000) begin
          a_word_nxt.bytes[0] = cp[7:0];
          a_word_nxt.bytes[1] = cp[15:8];
          a_word_nxt.last_idx = 2'd1;
        end else begin
          a_word_nxt.bytes[0] = u0[7:0];
          a_word_nxt.bytes[1] = u0[15:8];
          a_word_nxt.bytes[2] = u1[7:0];
          a_word_nxt.bytes[3] = u1[15:8];
          a_word_nxt.last_idx = 2'd3;
        end
      end
      CODEC_UTF16BE: begin
        if (reject) begin
          a_word_nxt.bad = 1'b1;
        end else if (cp < 32'h1_0000) begin
          a_word_nxt.bytes[0] = cp[15:8];
          a_word_nxt.bytes[1] = cp[7:0];
          a_word_nxt.last_idx = 2'd1;
        end else begin
          a_word_nxt.bytes[0] = u0[15:8];
          a_word_nxt.bytes[1] = u0[7:0];
          a_word_nxt.bytes[2] = u1[15:8];
          a_word_nxt.bytes[3] = u1[7:0];
          a_word_nxt.last_idx = 2'd3;
        end
      end
      CODEC_UTF32LE: begin
        a_word_nxt.bytes    = {cp[31:24], cp[23:16], cp[15:8], cp[7:0]};
        a_word_nxt.last_idx = 2'd3;
      end
      CODEC_UTF32BE: begin
        a_word_nxt.bytes    = {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
        a_word_nxt.last_idx = 2'd3;
      end
      default: begin
        // unassigned selector: request is consumed, nothing is sent
        codec_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_fire) begin
      a_valid_nxt = codec_ok;
    end else if (word_take) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_word_r <= a_word_nxt;
    end
  end

  assign word_valid = a_valid_r;
  assign word       = a_word_r;

endmodule

>>> design/cpub_ser.sv
module cpub_ser import cpub_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              word_valid,
  input  enc_word_t         word,
  output logic              word_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ByteW-1:0]  out_byte,
  output logic              out_last_byte,
  output logic              out_invalid
);

  logic            b_valid_r, b_valid_nxt;
  enc_word_t       b_word_r;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            out_fire;
  logic            b_done;

  assign out_fire  = b_valid_r && !out_stall;
  assign b_done    = out_fire && (idx_r == b_word_r.last_idx);
  // next word loads as the last byte of the current one leaves
  assign word_take = word_valid && (!b_valid_r || b_done);

  always_comb begin
    b_valid_nxt = b_valid_r;
    idx_nxt     = idx_r;
    if (word_take) begin
      b_valid_nxt = 1'b1;
      idx_nxt     = '0;
    end else if (b_done) begin
      b_valid_nxt = 1'b0;
    end else if (out_fire) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      b_valid_r <= b_valid_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (word_take) begin
      b_word_r <= word;
    end
  end

  assign out_valid     = b_valid_r;
  assign out_byte      = b_word_r.bytes[idx_r];
  assign out_last_byte = (idx_r == b_word_r.last_idx);
  assign out_invalid   = b_word_r.bad;

endmodule

>>> design/code_point_to_utf_bytes.sv
// First byte of a request is offered once its word has passed the encoder register and been
// loaded into the serializer register, which waits while an earlier word is still sent.
// Throughput: one result byte per cycle while not stalled, set by the byte-wide register;
// a code point is 1 to 4 result bytes (UTF-8 1..4, UTF-16 2 or 4, UTF-32 4, rejected 1).
// A new request is taken while the previous one is still being sent.
// Reset (synchronous, active low) empties both stages and sets the codec to UTF-8.
module code_point_to_utf_bytes import cpub_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SelW-1:0]   cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CpW-1:0]    in_code_point,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ByteW-1:0]  out_byte,
  output logic              out_last_byte,
  output logic              out_invalid
);

  logic [SelW-1:0] codec_r;
  logic            word_valid;
  logic            word_take;
  enc_word_t       word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r <= CODEC_RESET;
    end else if (cfg_wr_en) begin
      codec_r <= cfg_wr_data;
    end
  end

  cpub_enc u_enc (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_code_point (in_code_point),
    .in_stall      (in_stall),
    .codec         (codec_r),
    .word_take     (word_take),
    .word_valid    (word_valid),
    .word          (word)
  );

  cpub_ser u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .word_valid    (word_valid),
    .word          (word),
    .word_take     (word_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte),
    .out_invalid   (out_invalid)
  );

endmodule
